>>> hdl/tlpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie longest-prefix match: shared types
// Request and result beats, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tlpm_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address_bits;
    logic [5:0]  bit_count;
    logic [15:0] route_in;
  } req_t;

  typedef struct packed {
    logic        route_found;
    logic [15:0] route_out;
    logic        table_full;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

>>> hdl/trie_longest_prefix_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie longest-prefix match
// Binary trie of routing prefixes with insert and longest-match lookup.
//
// A request beat is taken at a rising edge with start high and busy low.
// req_type selects insert or lookup; bit_count leading bits of address_bits
// are walked, most significant first, saturated to the address width.
// The walk visits one trie node per cycle, limited by the single read port
// of the node store. busy stays high for the whole item. The result beat is
// shown for one cycle with result_valid high; the receiver has no way to
// stall it. A lookup returns the route of the deepest marked node, the root
// counting as the default route. An insert that runs out of nodes reports
// table_full. Reset empties the root and the free-node pointer; no clearing
// pass runs, so the block takes a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module trie_longest_prefix_match #(
  parameter int ADDR_BITS  = 32,
  parameter int NODE_COUNT = 1024,
  parameter int ROUTE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tlpm_pkg::req_t  req,
  output logic            result_valid,
  output tlpm_pkg::rsp_t  result
);
  import tlpm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tlpm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  tlpm_datapath #(
    .ADDR_BITS  (ADDR_BITS),
    .NODE_COUNT (NODE_COUNT),
    .ROUTE_BITS (ROUTE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .result (result)
  );

endmodule

>>> hdl/tlpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie longest-prefix match: controller
// Sequences one request through load, the per-bit walk and the result beat.
// ----------------------------------------------------------------------------
module tlpm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tlpm_pkg::dp_status_t   status,
  output tlpm_pkg::ctrl_cmd_t    cmd,
  output logic                   busy,
  output logic                   result_valid
);
  import tlpm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        result_valid = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/tlpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie longest-prefix match: datapath
// Node store, root node, walk registers and the per-bit insert and lookup step.
// ----------------------------------------------------------------------------
module tlpm_datapath #(
  parameter int ADDR_BITS  = 32,
  parameter int NODE_COUNT = 1024,
  parameter int ROUTE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tlpm_pkg::ctrl_cmd_t   cmd,
  input  tlpm_pkg::req_t        req,
  output tlpm_pkg::dp_status_t  status,
  output tlpm_pkg::rsp_t        result
);
  import tlpm_pkg::*;

  localparam int IW   = $clog2(NODE_COUNT);
  localparam int FW   = $clog2(NODE_COUNT + 1);
  localparam int CNTW = $clog2(ADDR_BITS + 1);

  typedef struct packed {
    logic [IW-1:0]         kid1;
    logic [IW-1:0]         kid0;
    logic                  marked;
    logic [ROUTE_BITS-1:0] route;
  } node_t;

  node_t mem [NODE_COUNT];
  node_t rdata;
  node_t root;

  logic                  is_lookup;
  logic [CNTW-1:0]       remaining;
  logic [ADDR_BITS-1:0]  addr_sh;
  logic [IW-1:0]         cur_idx;
  logic                  fresh;
  logic                  found;
  logic [ROUTE_BITS-1:0] best;
  logic [ROUTE_BITS-1:0] route_reg;
  logic [FW-1:0]         next_free;

  node_t                 cur;
  logic                  cur_bit;
  logic [IW-1:0]         child;
  logic                  vis_found;
  logic [ROUTE_BITS-1:0] vis_best;
  logic                  last;
  logic                  move;
  logic                  alloc;
  logic                  full;
  logic                  wr_en;
  node_t                 wr_data;
  logic [CNTW-1:0]       load_count;

  always_comb begin
    if ({26'b0, req.bit_count} > ADDR_BITS) begin
      load_count = CNTW'(ADDR_BITS);
    end else begin
      load_count = CNTW'(req.bit_count);
    end
  end

  always_comb begin
    if (fresh) begin
      cur = '0;
    end else if (cur_idx == '0) begin
      cur = root;
    end else begin
      cur = rdata;
    end
    cur_bit   = addr_sh[ADDR_BITS-1];
    child     = cur_bit ? cur.kid1 : cur.kid0;
    vis_found = found | cur.marked;
    vis_best  = cur.marked ? cur.route : best;
    last      = 1'b0;
    move      = 1'b0;
    alloc     = 1'b0;
    full      = 1'b0;
    wr_en     = 1'b0;
    wr_data   = cur;
    if (is_lookup) begin
      if (remaining == '0 || child == '0) begin
        last = 1'b1;
      end else begin
        move = 1'b1;
      end
    end else if (remaining == '0) begin
      last           = 1'b1;
      wr_en          = 1'b1;
      wr_data.marked = 1'b1;
      wr_data.route  = route_reg;
    end else if (child != '0) begin
      move = 1'b1;
    end else if (next_free >= FW'(NODE_COUNT)) begin
      last  = 1'b1;
      full  = 1'b1;
      wr_en = fresh;
    end else begin
      alloc = 1'b1;
      wr_en = 1'b1;
      if (cur_bit) begin
        wr_data.kid1 = IW'(next_free);
      end else begin
        wr_data.kid0 = IW'(next_free);
      end
    end
  end

  assign status.last = cmd.step & last;

  always_ff @(posedge clk) begin
    rdata <= mem[child];
    if (cmd.step && wr_en && cur_idx != '0) begin
      mem[cur_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root      <= '0;
      next_free <= FW'(1);
    end else if (cmd.step) begin
      if (wr_en && cur_idx == '0) begin
        root <= wr_data;
      end
      if (alloc) begin
        next_free <= next_free + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_lookup <= (req.req_type == REQ_LOOKUP);
      remaining <= load_count;
      addr_sh   <= ADDR_BITS'(req.address_bits);
      cur_idx   <= '0;
      fresh     <= 1'b0;
      found     <= 1'b0;
      best      <= '0;
      route_reg <= ROUTE_BITS'(req.route_in);
    end else if (cmd.step) begin
      if (move || alloc) begin
        remaining <= remaining - CNTW'(1);
        addr_sh   <= addr_sh << 1;
        found     <= vis_found;
        best      <= vis_best;
      end
      if (move) begin
        cur_idx <= child;
      end else if (alloc) begin
        cur_idx <= IW'(next_free);
        fresh   <= 1'b1;
      end
      if (last) begin
        if (is_lookup) begin
          result.route_found <= vis_found;
          result.route_out   <= 16'(vis_best);
          result.table_full  <= 1'b0;
        end else begin
          result.route_found <= 1'b0;
          result.route_out   <= '0;
          result.table_full  <= full;
        end
      end
    end
  end

endmodule

>>> bench/trie_longest_prefix_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie longest-prefix match testbench
// Drives insert and lookup beats into the block in random bursts, keeps a
// software copy of the trie that predicts every result beat, and compares
// each result beat field by field. Inserts are clustered around a few prefix
// bases so that lookups find deep matches; a late phase fills the node store
// so that abandoned inserts and inserts into a full table are exercised.
// ----------------------------------------------------------------------------

class route_trie_scoreboard;
  localparam int NODES  = 1024;
  localparam int ADDR_W = 32;

  int unsigned    child [NODES][2];
  bit             marked [NODES];
  logic [15:0]    route [NODES];
  int unsigned    next_free;
  tlpm_pkg::rsp_t awaited_rsps [$];
  int unsigned    failures;

  function new();
    child[0][0] = 0;
    child[0][1] = 0;
    marked[0]   = 1'b0;
    route[0]    = '0;
    next_free   = 1;
    failures    = 0;
  endfunction

  function tlpm_pkg::rsp_t walk_trie(tlpm_pkg::req_t r);
    tlpm_pkg::rsp_t rsp;
    int unsigned    depth;
    int unsigned    node;
    int unsigned    nxt;
    int unsigned    span;
    bit             b;
    rsp  = '0;
    node = 0;
    span = (r.bit_count > ADDR_W) ? ADDR_W : r.bit_count;
    if (r.req_type == tlpm_pkg::REQ_INSERT) begin
      for (depth = 0; depth < span; depth++) begin
        b   = r.address_bits[ADDR_W - 1 - depth];
        nxt = child[node][b];
        if (nxt == 0) begin
          if (next_free >= NODES) begin
            rsp.table_full = 1'b1;
            return rsp;
          end
          nxt = next_free;
          next_free++;
          child[nxt][0] = 0;
          child[nxt][1] = 0;
          marked[nxt]   = 1'b0;
          route[nxt]    = '0;
          child[node][b] = nxt;
        end
        node = nxt;
      end
      marked[node] = 1'b1;
      route[node]  = r.route_in;
    end else begin
      rsp.route_found = marked[0];
      rsp.route_out   = marked[0] ? route[0] : '0;
      for (depth = 0; depth < span; depth++) begin
        nxt = child[node][r.address_bits[ADDR_W - 1 - depth]];
        if (nxt == 0) break;
        node = nxt;
        if (marked[node]) begin
          rsp.route_found = 1'b1;
          rsp.route_out   = route[node];
        end
      end
    end
    return rsp;
  endfunction

  function void note_request(tlpm_pkg::req_t r);
    awaited_rsps.insert(awaited_rsps.size(), walk_trie(r));
  endfunction

  function void check_result(tlpm_pkg::rsp_t got);
    tlpm_pkg::rsp_t want;
    if (awaited_rsps.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("ERROR: unexpected result beat found=%0d route=%h full=%0d",
                 got.route_found, got.route_out, got.table_full);
      end
      return;
    end
    want = awaited_rsps.pop_front();
    if (got.route_found !== want.route_found || got.route_out !== want.route_out ||
        got.table_full !== want.table_full) begin
      failures++;
      if (failures <= 10) begin
        $display("ERROR: expected found=%0d route=%h full=%0d, got found=%0d route=%h full=%0d",
                 want.route_found, want.route_out, want.table_full,
                 got.route_found, got.route_out, got.table_full);
      end
    end
  endfunction
endclass

module trie_longest_prefix_match_test;
  import tlpm_pkg::*;

  localparam int RANDOM_ITEMS = 1180;
  localparam int FILL_START   = 850;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy;
  logic  result_valid;
  rsp_t  result;

  route_trie_scoreboard board;
  logic [31:0]          prefix_bases [8];
  int unsigned          burst_left = 0;
  int unsigned          cycle_count = 0;

  trie_longest_prefix_match i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("trie_longest_prefix_match verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      board.check_result(result);
    end
  end

  function automatic req_t make_req(logic kind, logic [31:0] addr, logic [5:0] len,
                                    logic [15:0] rt);
    req_t r;
    r.req_type     = kind;
    r.address_bits = addr;
    r.bit_count    = len;
    r.route_in     = rt;
    return r;
  endfunction

  function automatic req_t random_request(bit filling);
    req_t        r;
    int unsigned keep;
    logic [31:0] hi_mask;
    logic [31:0] base;
    r.req_type = ($urandom_range(0, 9) < (filling ? 5 : 4)) ? REQ_INSERT : REQ_LOOKUP;
    r.route_in = 16'($urandom);
    base       = prefix_bases[$urandom_range(0, 7)];
    keep       = $urandom_range(0, 32);
    hi_mask    = 32'hFFFF_FFFF << (32 - keep);
    r.address_bits = (base & hi_mask) | ($urandom & ~hi_mask);
    case ($urandom_range(0, 9))
      0:       r.bit_count = 6'($urandom_range(33, 63));
      1, 2, 3: r.bit_count = 6'd32;
      default: r.bit_count = 6'($urandom_range(0, 32));
    endcase
    if (filling && r.req_type == REQ_INSERT && $urandom_range(0, 1) == 1) begin
      r.address_bits = $urandom;
      r.bit_count    = 6'($urandom_range(24, 32));
    end
    return r;
  endfunction

  task automatic idle_cycles(int unsigned n);
    logic [63:0] noise;
    start <= 1'b0;
    repeat (n) begin
      noise = {$urandom, $urandom};
      req <= req_t'(noise[$bits(req_t)-1:0]);
      @(posedge clk);
    end
  endtask

  task automatic issue_request(req_t r);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(1, 40));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    board.note_request(r);
  endtask

  initial begin
    board = new();
    prefix_bases[0] = 32'h0000_0000;
    prefix_bases[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) prefix_bases[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then the default route through the empty prefix.
    issue_request(make_req(REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000));
    issue_request(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'hFFFF));
    issue_request(make_req(REQ_INSERT, 32'h1357_9BDF, 6'd0, 16'h1234));
    issue_request(make_req(REQ_LOOKUP, 32'h2468_ACE0, 6'd0, 16'h0000));
    issue_request(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hABCD));
    // Full-length prefixes, overlong lengths and overwriting a route.
    issue_request(make_req(REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF));
    issue_request(make_req(REQ_INSERT, 32'hFFFF_FFFF, 6'd63, 16'h0000));
    issue_request(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h5555));
    issue_request(make_req(REQ_INSERT, 32'h8000_0000, 6'd1, 16'h00A5));
    issue_request(make_req(REQ_LOOKUP, 32'hC000_0000, 6'd32, 16'h0000));
    issue_request(make_req(REQ_INSERT, 32'h0000_0000, 6'd32, 16'h5A5A));
    issue_request(make_req(REQ_LOOKUP, 32'h0000_0001, 6'd32, 16'h0000));
    issue_request(make_req(REQ_LOOKUP, 32'h0000_0000, 6'd31, 16'h0000));
    issue_request(make_req(REQ_LOOKUP, 32'h0000_0000, 6'd40, 16'h0000));
    issue_request(make_req(REQ_INSERT, 32'h0000_0000, 6'd16, 16'h0F0F));
    issue_request(make_req(REQ_LOOKUP, 32'h0000_FFFF, 6'd32, 16'h0000));
    issue_request(make_req(REQ_INSERT, 32'hAAAA_AAAA, 6'd32, 16'h8001));
    issue_request(make_req(REQ_LOOKUP, 32'hAAAA_AAAA, 6'd40, 16'h0000));
    issue_request(make_req(REQ_INSERT, 32'h5555_5555, 6'd33, 16'h0001));
    issue_request(make_req(REQ_LOOKUP, 32'h5555_5554, 6'd32, 16'h0000));
    issue_request(make_req(REQ_INSERT, 32'hFFFF_FFFF, 6'd0, 16'h7E7E));
    issue_request(make_req(REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue_request(random_request(n >= FILL_START));
    end

    start <= 1'b0;
    while (board.awaited_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.awaited_rsps.size() == 0) begin
      $display("trie_longest_prefix_match verification clean");
    end else begin
      $display("trie_longest_prefix_match verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tlpm_pkg.sv
hdl/tlpm_ctrl.sv
hdl/tlpm_datapath.sv
hdl/trie_longest_prefix_match.sv
bench/trie_longest_prefix_match_test.sv
